>>> rtl/core/smm_pkg.sv
package smm_pkg;

  // default sizes
  localparam int NUM_SEGMENTS_DEF = 64;
  localparam int SEG_WORDS_DEF    = 1024;

  // request kinds
  localparam logic [2:0] KIND_FETCH    = 3'd0;
  localparam logic [2:0] KIND_MAP      = 3'd1;
  localparam logic [2:0] KIND_UNMAP    = 3'd2;
  localparam logic [2:0] KIND_LOAD     = 3'd3;
  localparam logic [2:0] KIND_STORE    = 3'd4;
  localparam logic [2:0] KIND_LOADPROG = 3'd5;

  // response status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // request word
  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  segment;
    logic [9:0]  offset;
    logic [31:0] word_value;
    logic [10:0] map_len;
  } req_t;

  // response word
  typedef struct packed {
    logic [31:0] data;
    logic        done_res;
    logic [1:0]  status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic commit;
    logic zero_step;
    logic copy_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic walk_zero;
    logic walk_copy;
    logic zero_last;
    logic copy_last;
  } sts_t;

endpackage

>>> rtl/core/smm_ctrl.sv
module smm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  smm_pkg::sts_t sts,
  output smm_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_ZERO = 4'b0100,
    S_COPY = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // result goes straight to the output register, so wait for it
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          priority if (sts.walk_zero) begin
            state_next = S_ZERO;
          end else if (sts.walk_copy) begin
            state_next = S_COPY;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_ZERO: begin
        cmd.zero_step = 1'b1;
        if (sts.zero_last) begin
          state_next = S_IDLE;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

endmodule

>>> rtl/core/smm_datapath.sv
module smm_datapath #(
  parameter int NUM_SEGMENTS = smm_pkg::NUM_SEGMENTS_DEF,
  parameter int SEG_WORDS    = smm_pkg::SEG_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  smm_pkg::req_t req,
  input  smm_pkg::cmd_t cmd,
  output smm_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output smm_pkg::rsp_t rsp
);

  localparam int SEG_W     = $clog2(NUM_SEGMENTS);
  localparam int WORD_AW   = $clog2(SEG_WORDS);
  localparam int LEN_W     = $clog2(SEG_WORDS + 1);
  localparam int FC_W      = $clog2(NUM_SEGMENTS + 1);
  localparam int PC_W      = (LEN_W > 10) ? LEN_W : 10;
  localparam int ENT_W     = LEN_W + 1;
  localparam int MEM_AW    = SEG_W + WORD_AW;
  localparam int MEM_DEPTH = NUM_SEGMENTS * (2 ** WORD_AW);

  // memories: segment table {live, length}, free stack, word store
  logic [ENT_W-1:0] seg_tab  [NUM_SEGMENTS];
  logic [SEG_W-1:0] free_mem [NUM_SEGMENTS];
  logic [31:0]      word_mem [MEM_DEPTH];

  logic [ENT_W-1:0] tab_rd;
  logic [SEG_W-1:0] free_rd;
  logic [31:0]      word_rd;

  // control registers
  logic [FC_W-1:0]  free_count;
  logic [FC_W-1:0]  fresh_count;
  logic [PC_W-1:0]  pc;
  logic [LEN_W-1:0] len0;

  // held request and walk registers
  smm_pkg::req_t    item_q;
  logic [SEG_W-1:0] walk_id;
  logic [LEN_W-1:0] walk_len;
  logic [LEN_W-1:0] walk_cnt;
  logic [LEN_W-1:0] cnt_prev;

  // decode
  logic             is_fetch, is_map, is_unmap, is_store, is_lp;
  logic             seg_nonzero, seg_live, off_ok, pc_done;
  logic [LEN_W-1:0] seg_len;
  logic [PC_W-1:0]  off_q_ext;
  logic [PC_W-1:0]  off_in_ext;
  logic             too_big, have_free, have_fresh, map_ok, unmap_ok, push_ok;
  logic             lp_ok;
  logic [SEG_W-1:0] new_id;
  smm_pkg::rsp_t    res;

  // memory port controls
  logic              tab_we;
  logic [SEG_W-1:0]  tab_waddr;
  logic [ENT_W-1:0]  tab_wdata;
  logic              wm_we;
  logic              wm_re;
  logic [MEM_AW-1:0] wm_waddr;
  logic [MEM_AW-1:0] wm_raddr;
  logic [31:0]       wm_wdata;

  assign is_fetch = (item_q.kind == smm_pkg::KIND_FETCH);
  assign is_map   = (item_q.kind == smm_pkg::KIND_MAP);
  assign is_unmap = (item_q.kind == smm_pkg::KIND_UNMAP);
  assign is_store = (item_q.kind == smm_pkg::KIND_STORE);
  assign is_lp    = (item_q.kind == smm_pkg::KIND_LOADPROG);

  // an ID at or above the fresh count has never been mapped
  assign seg_nonzero = (item_q.segment != '0);
  assign seg_live    = !seg_nonzero ||
                       ((32'(item_q.segment) < 32'(fresh_count)) && tab_rd[LEN_W]);
  assign seg_len     = seg_nonzero ? tab_rd[LEN_W-1:0] : len0;
  assign off_q_ext   = PC_W'(item_q.offset);
  assign off_in_ext  = PC_W'(req.offset);
  assign off_ok      = (32'(item_q.offset) < 32'(seg_len));
  assign pc_done     = (32'(pc) >= 32'(len0));

  // map picks the top of the free stack, else the next fresh ID
  assign too_big    = (32'(item_q.map_len) > 32'(SEG_WORDS));
  assign have_free  = (free_count != '0);
  assign have_fresh = (32'(fresh_count) < 32'(NUM_SEGMENTS));
  assign map_ok     = !too_big && (have_free || have_fresh);
  assign new_id     = have_free ? free_rd : SEG_W'(fresh_count);
  assign unmap_ok   = seg_nonzero && seg_live;
  assign push_ok    = (32'(free_count) < 32'(NUM_SEGMENTS));
  assign lp_ok      = !seg_nonzero || seg_live;

  // response for the held request
  always_comb begin
    res = '0;
    res.status = smm_pkg::ST_OK;
    unique case (item_q.kind)
      smm_pkg::KIND_FETCH: begin
        if (pc_done) begin
          res.done_res = 1'b1;
        end else begin
          res.data = word_rd;
        end
      end
      smm_pkg::KIND_MAP: begin
        if (!map_ok) begin
          res.status = smm_pkg::ST_FULL;
        end else begin
          res.data = 32'(new_id);
        end
      end
      smm_pkg::KIND_UNMAP: begin
        if (!unmap_ok) begin
          res.status = smm_pkg::ST_UNMAPPED;
        end
      end
      smm_pkg::KIND_LOAD: begin
        priority if (!seg_live) begin
          res.status = smm_pkg::ST_UNMAPPED;
        end else if (!off_ok) begin
          res.status = smm_pkg::ST_RANGE;
        end else begin
          res.data = word_rd;
        end
      end
      smm_pkg::KIND_STORE: begin
        priority if (!seg_live) begin
          res.status = smm_pkg::ST_UNMAPPED;
        end else if (!off_ok) begin
          res.status = smm_pkg::ST_RANGE;
        end
      end
      smm_pkg::KIND_LOADPROG: begin
        if (!lp_ok) begin
          res.status = smm_pkg::ST_UNMAPPED;
        end
      end
      default: begin
      end
    endcase
  end

  // status to controller
  assign cnt_prev      = walk_cnt - LEN_W'(1);
  assign sts.out_free  = !rsp_valid || !rsp_stall;
  assign sts.walk_zero = is_map && map_ok && (item_q.map_len != '0);
  assign sts.walk_copy = is_lp && seg_nonzero && seg_live && (seg_len != '0);
  assign sts.zero_last = ((walk_cnt + LEN_W'(1)) == walk_len);
  assign sts.copy_last = (walk_cnt == walk_len);

  // segment table write: map sets live and length, unmap clears
  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = SEG_W'(item_q.segment);
    tab_wdata = '0;
    if (cmd.commit && is_map && map_ok) begin
      tab_we    = 1'b1;
      tab_waddr = new_id;
      tab_wdata = {1'b1, LEN_W'(item_q.map_len)};
    end else if (cmd.commit && is_unmap && unmap_ok) begin
      tab_we = 1'b1;
    end
  end

  // word store ports
  always_comb begin
    wm_we    = 1'b0;
    wm_waddr = {SEG_W'(item_q.segment), off_q_ext[WORD_AW-1:0]};
    wm_wdata = item_q.word_value;
    priority if (cmd.commit && is_store && seg_live && off_ok) begin
      wm_we = 1'b1;
    end else if (cmd.zero_step) begin
      wm_we    = 1'b1;
      wm_waddr = {walk_id, walk_cnt[WORD_AW-1:0]};
      wm_wdata = '0;
    end else if (cmd.copy_step && (walk_cnt != '0)) begin
      // data read in the previous cycle lands in segment 0
      wm_we    = 1'b1;
      wm_waddr = {SEG_W'(0), cnt_prev[WORD_AW-1:0]};
      wm_wdata = word_rd;
    end else begin
      wm_we = 1'b0;
    end
  end

  always_comb begin
    wm_re    = 1'b0;
    wm_raddr = {SEG_W'(req.segment), off_in_ext[WORD_AW-1:0]};
    priority if (cmd.copy_step) begin
      wm_re    = (walk_cnt != walk_len);
      wm_raddr = {walk_id, walk_cnt[WORD_AW-1:0]};
    end else if (cmd.accept) begin
      wm_re = 1'b1;
      if (req.kind == smm_pkg::KIND_FETCH) begin
        wm_raddr = {SEG_W'(0), pc[WORD_AW-1:0]};
      end
    end else begin
      wm_re = 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (wm_we) begin
      word_mem[wm_waddr] <= wm_wdata;
    end
    if (wm_re) begin
      word_rd <= word_mem[wm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      seg_tab[tab_waddr] <= tab_wdata;
    end
    if (cmd.accept) begin
      tab_rd <= seg_tab[SEG_W'(req.segment)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && is_unmap && unmap_ok && push_ok) begin
      free_mem[SEG_W'(free_count)] <= SEG_W'(item_q.segment);
    end
    if (cmd.accept) begin
      free_rd <= free_mem[SEG_W'(free_count - FC_W'(1))];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count  <= '0;
      fresh_count <= FC_W'(1);
      pc          <= '0;
      len0        <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (is_fetch && !pc_done) begin
          pc <= pc + PC_W'(1);
        end
        if (is_map && map_ok) begin
          if (have_free) begin
            free_count <= free_count - FC_W'(1);
          end else begin
            fresh_count <= fresh_count + FC_W'(1);
          end
        end
        if (is_unmap && unmap_ok && push_ok) begin
          free_count <= free_count + FC_W'(1);
        end
        if (is_lp && lp_ok) begin
          pc <= off_q_ext;
          if (seg_nonzero) begin
            len0 <= seg_len;
          end
        end
      end
      // output register
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_q <= req;
    end
    if (cmd.commit) begin
      rsp      <= res;
      walk_id  <= is_map ? new_id : SEG_W'(item_q.segment);
      walk_len <= is_map ? LEN_W'(item_q.map_len) : seg_len;
      walk_cnt <= '0;
    end else if (cmd.zero_step || cmd.copy_step) begin
      walk_cnt <= walk_cnt + LEN_W'(1);
    end
  end

  // freed IDs are always a subset of the handed-out nonzero IDs
  a_free_below_fresh: assert property (@(posedge clk) disable iff (rst)
    32'(free_count) < 32'(fresh_count))
    else $error("free stack deeper than handed-out IDs");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fresh_count) <= 32'(NUM_SEGMENTS))
    else $error("fresh count past segment count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !cmd.commit)
    else $error("response overwritten while stalled");

  a_zero_not_seg0: assert property (@(posedge clk) disable iff (rst)
    cmd.zero_step |-> (walk_id != '0))
    else $error("zeroing walk targets segment 0");

  a_copy_len0: assert property (@(posedge clk) disable iff (rst)
    (cmd.copy_step && (walk_cnt == walk_len)) |=> (len0 == $past(walk_len)))
    else $error("segment 0 length differs from copied length");

endmodule

>>> rtl/core/segmented_memory_manager.sv
// Segmented word memory of a small virtual machine.
// Request channel (req_valid / req_stall / req): one word per operation:
// fetch, map, unmap, load, store or load program. Response channel
// (rsp_valid / rsp_stall / rsp): exactly one word per request, in order,
// carrying data, done_res and status.
// Timing: when a request is taken, its memories are read at that edge; the
// decision step then decides it and writes the response register once that
// register is free. The registered read of the word store is why the
// decision comes after the accept. Map of a nonempty segment then zeroes it
// word by word; load program from a nonzero segment copies its words into
// segment 0 one by one through the single write port.
// The response register parts the channels: a new request is taken while a
// response waits, but the following decision waits until that word leaves.
// Reset: no clearing pass. Segment 0 is mapped and empty, program counter 0,
// free stack empty; IDs never handed out read as unmapped.
// A stalled response holds its word; requests are stalled while busy.
module segmented_memory_manager #(
  parameter int NUM_SEGMENTS = smm_pkg::NUM_SEGMENTS_DEF,
  parameter int SEG_WORDS    = smm_pkg::SEG_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  smm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output smm_pkg::rsp_t rsp
);

  smm_pkg::cmd_t cmd;
  smm_pkg::sts_t sts;

  // sequencer
  smm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // memories, counters and response register
  smm_datapath #(
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .SEG_WORDS    (SEG_WORDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> tb/sv/segmented_memory_manager_tb.sv
module segmented_memory_manager_tb;

  localparam int NUM_SEG         = smm_pkg::NUM_SEGMENTS_DEF;
  localparam int SEG_W           = smm_pkg::SEG_WORDS_DEF;
  localparam int RANDOM_ITEMS    = 1225;
  localparam int TAIL_ITEMS      = 150;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 6000;
  localparam int DRAIN_CYCLES    = 20;

  // kinds the block treats as no-ops
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  // Shadow of the segment memory; predicts one response word per request word
  class seg_memory_model;
    bit [10:0]     seg_len [NUM_SEG];
    bit            seg_live [NUM_SEG];
    bit [5:0]      free_ids [NUM_SEG];
    int            free_cnt;
    int            fresh_cnt;
    bit [10:0]     pc;
    bit [31:0]     words [NUM_SEG * SEG_W];
    smm_pkg::rsp_t pending_rsp [$];
    int            mismatches;

    function new();
      seg_live[0] = 1'b1;
      fresh_cnt   = 1;
    endfunction

    // random live ID, 0 when nothing else is live
    function int live_id(bit allow_zero);
      int ids [$];
      for (int s = allow_zero ? 0 : 1; s < NUM_SEG; s++)
        if (seg_live[s]) ids.push_back(s);
      if (ids.size() == 0) return 0;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    // apply one accepted request and queue the response it should give
    function void predict(smm_pkg::req_t r);
      smm_pkg::rsp_t e;
      int            id;
      int            k;
      e = '0;
      case (r.kind)
        smm_pkg::KIND_FETCH: begin
          if (pc >= seg_len[0]) begin
            e.done_res = 1'b1;
          end else begin
            e.data = words[pc];
            pc++;
          end
        end
        smm_pkg::KIND_MAP: begin
          if (r.map_len > SEG_W || (free_cnt == 0 && fresh_cnt >= NUM_SEG)) begin
            e.status = smm_pkg::ST_FULL;
          end else begin
            // most recently freed ID wins over a fresh one
            if (free_cnt > 0) begin
              free_cnt--;
              id = free_ids[free_cnt];
            end else begin
              id = fresh_cnt;
              fresh_cnt++;
            end
            for (k = 0; k < r.map_len; k++) words[id * SEG_W + k] = '0;
            seg_len[id]  = r.map_len;
            seg_live[id] = 1'b1;
            e.data       = 32'(id);
          end
        end
        smm_pkg::KIND_UNMAP: begin
          if (r.segment == 0 || !seg_live[r.segment]) begin
            e.status = smm_pkg::ST_UNMAPPED;
          end else begin
            seg_live[r.segment] = 1'b0;
            seg_len[r.segment]  = '0;
            if (free_cnt < NUM_SEG) begin
              free_ids[free_cnt] = r.segment;
              free_cnt++;
            end
          end
        end
        smm_pkg::KIND_LOAD, smm_pkg::KIND_STORE: begin
          if (!seg_live[r.segment])
            e.status = smm_pkg::ST_UNMAPPED;
          else if (r.offset >= seg_len[r.segment])
            e.status = smm_pkg::ST_RANGE;
          else if (r.kind == smm_pkg::KIND_LOAD)
            e.data = words[r.segment * SEG_W + r.offset];
          else
            words[r.segment * SEG_W + r.offset] = r.word_value;
        end
        smm_pkg::KIND_LOADPROG: begin
          if (r.segment != 0 && !seg_live[r.segment]) begin
            e.status = smm_pkg::ST_UNMAPPED;
          end else begin
            // segment 0 only moves the program counter
            if (r.segment != 0) begin
              for (k = 0; k < seg_len[r.segment]; k++)
                words[k] = words[r.segment * SEG_W + k];
              seg_len[0] = seg_len[r.segment];
            end
            pc = 11'(r.offset);
          end
        end
        default: ;
      endcase
      pending_rsp.push_back(e);
    endfunction

    // compare one accepted response word against the oldest prediction
    function void check(smm_pkg::rsp_t got);
      smm_pkg::rsp_t e;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response data %h done_res %b status %0d",
                 $time, got.data, got.done_res, got.status);
        mismatches++;
        return;
      end
      e = pending_rsp.pop_front();
      if (got.data !== e.data) begin
        $display("%0t: data expected %h got %h", $time, e.data, got.data);
        mismatches++;
      end
      if (got.done_res !== e.done_res) begin
        $display("%0t: done_res expected %b got %b", $time, e.done_res, got.done_res);
        mismatches++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  smm_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_stall;
  smm_pkg::rsp_t rsp;

  seg_memory_model mem_model = new();

  bit hold_off_now = 1'b0;
  bit quiet_tail   = 1'b0;
  int idle_cycles  = 0;

  segmented_memory_manager DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) mem_model.check(rsp);
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[segmented_memory_manager] ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, calm stretches, one long hold-off
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_now) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_off_now = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 15) < 3) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  function automatic smm_pkg::req_t word_of(logic [2:0] kind, logic [5:0] seg,
                                            logic [9:0] off, logic [31:0] val,
                                            logic [10:0] nw);
    smm_pkg::req_t r;
    r.kind       = kind;
    r.segment    = seg;
    r.offset     = off;
    r.word_value = val;
    r.map_len    = nw;
    return r;
  endfunction

  // offer one request word and hold it until taken
  task automatic send_word(input smm_pkg::req_t w);
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    mem_model.predict(w);
  endtask

  task automatic idle_sender(input int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_responses();
    req_valid <= 1'b0;
    while (mem_model.pending_rsp.size() != 0) @(posedge clk);
  endtask

  // random request, mostly aimed at live segments and valid offsets
  function automatic smm_pkg::req_t random_request(bit map_run);
    smm_pkg::req_t r;
    int            pick;
    int            id;
    int            len;
    r.kind       = 3'($urandom);
    r.segment    = 6'($urandom);
    r.offset     = 10'($urandom);
    r.word_value = $urandom;
    r.map_len    = 11'($urandom);
    pick         = $urandom_range(0, 99);
    if (map_run || pick < 12) begin
      r.kind = smm_pkg::KIND_MAP;
      case ($urandom_range(0, 49))
        0:       r.map_len = 11'(SEG_W);
        1:       r.map_len = 11'($urandom_range(SEG_W + 1, 2047));
        default: r.map_len = 11'($urandom_range(0, map_run ? 4 : 24));
      endcase
    end else if (pick < 22) begin
      r.kind = smm_pkg::KIND_UNMAP;
      if ($urandom_range(0, 4) != 0) r.segment = 6'(mem_model.live_id(1'b0));
    end else if (pick < 77) begin
      r.kind = pick < 50 ? smm_pkg::KIND_STORE :
               pick < 72 ? smm_pkg::KIND_LOAD : smm_pkg::KIND_LOADPROG;
      if ($urandom_range(0, 6) != 0) begin
        id        = mem_model.live_id(1'b1);
        len       = int'(mem_model.seg_len[id]);
        r.segment = 6'(id);
        // program counter may land just past the end
        if (r.kind == smm_pkg::KIND_LOADPROG)
          r.offset = 10'($urandom_range(0, len < 1022 ? len + 1 : 1023));
        else if (len > 0)
          r.offset = 10'($urandom_range(0, len - 1));
      end
    end else if (pick < 98) begin
      r.kind = smm_pkg::KIND_FETCH;
    end else begin
      r.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    end
    return r;
  endfunction

  // stimulus
  initial begin
    bit gaps_on;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty program, errors, size extremes, program run, ID reuse
    send_word(word_of(smm_pkg::KIND_FETCH, 0, 0, 0, 0));
    send_word(word_of(smm_pkg::KIND_STORE, 5, 0, 32'hDEADBEEF, 0));
    send_word(word_of(smm_pkg::KIND_UNMAP, 0, 0, 0, 0));
    send_word(word_of(smm_pkg::KIND_MAP, 0, 0, 0, 11'(SEG_W + 1)));
    send_word(word_of(smm_pkg::KIND_MAP, 63, 1023, 32'hFFFFFFFF, 2047));
    send_word(word_of(smm_pkg::KIND_MAP, 0, 0, 0, 0));
    send_word(word_of(smm_pkg::KIND_MAP, 0, 0, 0, 11'(SEG_W)));
    send_word(word_of(smm_pkg::KIND_STORE, 2, 1023, 32'hFFFFFFFF, 0));
    send_word(word_of(smm_pkg::KIND_LOAD, 2, 1023, 0, 0));
    send_word(word_of(smm_pkg::KIND_LOAD, 2, 512, 0, 0));
    send_word(word_of(smm_pkg::KIND_LOAD, 1, 0, 0, 0));
    send_word(word_of(smm_pkg::KIND_MAP, 0, 0, 0, 3));
    send_word(word_of(smm_pkg::KIND_STORE, 3, 0, 32'h0000_0001, 0));
    send_word(word_of(smm_pkg::KIND_STORE, 3, 3, 32'h0000_0002, 0));
    send_word(word_of(smm_pkg::KIND_LOADPROG, 3, 0, 0, 0));
    repeat (4) send_word(word_of(smm_pkg::KIND_FETCH, 0, 0, 0, 0));
    send_word(word_of(smm_pkg::KIND_LOADPROG, 0, 1023, 0, 0));
    send_word(word_of(smm_pkg::KIND_FETCH, 0, 0, 0, 0));
    send_word(word_of(smm_pkg::KIND_UNMAP, 3, 0, 0, 0));
    send_word(word_of(smm_pkg::KIND_UNMAP, 3, 0, 0, 0));
    send_word(word_of(smm_pkg::KIND_MAP, 0, 0, 0, 2));
    send_word(word_of(smm_pkg::KIND_LOADPROG, 40, 7, 0, 0));
    send_word(word_of(KIND_SPARE_A, 0, 0, 0, 0));
    send_word(word_of(KIND_SPARE_B, 0, 0, 0, 0));

    // random traffic with a run of maps that exhausts the IDs
    gaps_on = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0) gaps_on = $urandom_range(0, 2) != 0;
      if (n == 300) hold_off_now = 1'b1;
      if (n == 650) wait_for_responses();
      if (n == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
      send_word(random_request(n >= 400 && n < 480));
      if (gaps_on && !quiet_tail && !hold_off_now && $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 8));
    end

    // drain, then give the block time to show any extra word
    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mem_model.mismatches == 0)
      $display("[segmented_memory_manager] OK");
    else
      $display("[segmented_memory_manager] ERROR");
    $finish;
  end

endmodule
